>>> hw/rtl/sbh_pkg.sv
// Shared constants and status types for the string bucket hash block.
`timescale 1ns / 1ps
`default_nettype none

package sbh_pkg;

    localparam int ACC_BITS_DEF  = 64;
    localparam int CHAR_BITS_DEF = 16;
    localparam int UNIT_BITS     = 16;
    localparam int SIZE_BITS     = 31;
    localparam int DIGIT_BITS    = 16;
    localparam int SUM_BITS      = DIGIT_BITS + 6;
    localparam int HASH_MULT     = 37;

    localparam logic [SIZE_BITS-1:0] TABLE_SIZE_RESET = SIZE_BITS'(251);

    typedef struct packed {
        logic busy_hi;   // more than one digit left
        logic idle;
    } mac_stat_t;

    typedef struct packed {
        logic busy;      // dividing or holding a result
        logic valid;     // result held
    } rem_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/string_bucket_hash.sv
// String bucket hash: polynomial hash (x37) of a code unit stream, bucketed.
//
// Input channel: one code_unit per beat (in_valid / in_stall). Nonzero units
// fold into the accumulator; a zero unit ends the key and yields one output
// beat (bucket, hash_value) on out_valid / out_stall, then the accumulator
// clears for the next key.
// Each nonzero unit multiplies the accumulator by 37 one 16-bit digit per
// cycle, LSB first; the next unit is taken on the last digit cycle, so a
// new unit can be taken before the last one is through.
// A terminator is taken on the last digit cycle or later, so the divider
// starts on the next cycle; a bit-serial restoring divider works out the
// remainder and the result then loads the output register. A stalled
// output delays the load.
// Input stalls while the divider runs or holds a result. Once the result
// moves to the output register, units of the next key are taken while it
// waits.
// table_size is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block is idle (not enforced by the block); zero acts as
// one. Reset clears the accumulator, empties the output, table_size is 251.
`timescale 1ns / 1ps
`default_nettype none

module string_bucket_hash #(
    parameter int ACC_BITS  = sbh_pkg::ACC_BITS_DEF,
    parameter int CHAR_BITS = sbh_pkg::CHAR_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_wr_en,
    input  wire [sbh_pkg::SIZE_BITS-1:0]   cfg_wr_data,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire [sbh_pkg::UNIT_BITS-1:0]   code_unit,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [sbh_pkg::SIZE_BITS-1:0]  bucket,
    output logic [ACC_BITS-1:0]            hash_value
);

    localparam int UNIT_W = (CHAR_BITS < sbh_pkg::UNIT_BITS) ? CHAR_BITS
                                                             : sbh_pkg::UNIT_BITS;

    logic [sbh_pkg::SIZE_BITS-1:0]  table_size_reg;
    logic                           term_pend_reg;
    logic                           out_valid_reg;
    logic [sbh_pkg::SIZE_BITS-1:0]  bucket_reg;
    logic [ACC_BITS-1:0]            hash_reg;

    logic [UNIT_W-1:0]              unit;
    logic                           accept, is_term, mac_load, rem_start, take;
    logic [ACC_BITS-1:0]            acc;
    logic [sbh_pkg::SIZE_BITS-1:0]  rem_val;
    logic [ACC_BITS-1:0]            rem_hash;
    sbh_pkg::mac_stat_t             mac_stat;
    sbh_pkg::rem_stat_t             rem_stat;

    assign unit      = code_unit[UNIT_W-1:0];
    assign is_term   = unit == '0;
    assign in_stall  = mac_stat.busy_hi || term_pend_reg || rem_stat.busy;
    assign accept    = in_valid && !in_stall;
    assign mac_load  = accept && !is_term;
    assign rem_start = term_pend_reg && mac_stat.idle;
    assign take      = rem_stat.valid && (!out_valid_reg || !out_stall);

    sbh_mac #(
        .ACC_BITS (ACC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (mac_load),
        .unit  (sbh_pkg::DIGIT_BITS'(unit)),
        .clr   (rem_start),
        .acc   (acc),
        .stat  (mac_stat)
    );

    sbh_rem #(
        .ACC_BITS (ACC_BITS)
    ) u_rem (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (rem_start),
        .dividend     (acc),
        .divisor      (table_size_reg),
        .take         (take),
        .remainder    (rem_val),
        .dividend_out (rem_hash),
        .stat         (rem_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= sbh_pkg::TABLE_SIZE_RESET;
            term_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                table_size_reg <= cfg_wr_data;
            if (rem_start)
                term_pend_reg <= 1'b0;
            else if (accept && is_term)
                term_pend_reg <= 1'b1;
            if (take)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bucket_reg <= rem_val;
            hash_reg   <= rem_hash;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bucket     = bucket_reg;
    assign hash_value = hash_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sbh_mac.sv
// Digit-serial multiply-by-37 accumulate; holds the hash accumulator.
`timescale 1ns / 1ps
`default_nettype none

module sbh_mac #(
    parameter int ACC_BITS = sbh_pkg::ACC_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             load,
    input  wire [sbh_pkg::DIGIT_BITS-1:0]   unit,
    input  wire                             clr,
    output logic [ACC_BITS-1:0]             acc,
    output sbh_pkg::mac_stat_t              stat
);

    localparam int DIG   = sbh_pkg::DIGIT_BITS;
    localparam int NDIG  = (ACC_BITS + DIG - 1) / DIG;
    localparam int PAD   = NDIG * DIG;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [PAD-1:0]                   sh_reg, sh_next, step_sh;
    logic [DIG-1:0]                   carry_reg, carry_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [sbh_pkg::SUM_BITS-1:0]     sum;

    assign sum = sbh_pkg::SUM_BITS'(sh_reg[DIG-1:0])
               * sbh_pkg::SUM_BITS'(sbh_pkg::HASH_MULT)
               + sbh_pkg::SUM_BITS'(carry_reg);
    assign step_sh = {sum[DIG-1:0], sh_reg[PAD-1:DIG]};

    always_comb
    begin
        sh_next    = sh_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        if (clr)
        begin
            sh_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // last digit drops bits above the accumulator width
            if (cnt_reg == CNT_W'(1))
                sh_next = PAD'(step_sh[ACC_BITS-1:0]);
            else
                sh_next = step_sh;
            carry_next = DIG'(sum >> DIG);
            cnt_next   = cnt_reg - CNT_W'(1);
        end
        if (load)
        begin
            carry_next = unit;
            cnt_next   = CNT_W'(NDIG);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg    <= '0;
            cnt_reg   <= '0;
            carry_reg <= '0;
        end
        else
        begin
            sh_reg    <= sh_next;
            cnt_reg   <= cnt_next;
            carry_reg <= carry_next;
        end
    end

    assign acc          = sh_reg[ACC_BITS-1:0];
    assign stat.busy_hi = cnt_reg > CNT_W'(1);
    assign stat.idle    = cnt_reg == '0;

endmodule

`default_nettype wire

>>> hw/rtl/sbh_rem.sv
// Bit-serial restoring remainder of the accumulator by the table size.
`timescale 1ns / 1ps
`default_nettype none

module sbh_rem #(
    parameter int ACC_BITS = sbh_pkg::ACC_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire [ACC_BITS-1:0]             dividend,
    input  wire [sbh_pkg::SIZE_BITS-1:0]   divisor,
    input  wire                            take,
    output logic [sbh_pkg::SIZE_BITS-1:0]  remainder,
    output logic [ACC_BITS-1:0]            dividend_out,
    output sbh_pkg::rem_stat_t             stat
);

    localparam int SB    = sbh_pkg::SIZE_BITS;
    localparam int CNT_W = $clog2(ACC_BITS + 1);

    logic [ACC_BITS-1:0]  dvd_reg;
    logic [SB-1:0]        rem_reg;
    logic [SB-1:0]        dsr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 full_reg;
    logic [SB:0]          shifted;
    logic [SB:0]          diff;

    assign shifted = {rem_reg, dvd_reg[ACC_BITS-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            full_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(ACC_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                full_reg <= 1'b1;
        end
        else if (take)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= (divisor == '0) ? SB'(1) : divisor;
        end
        else if (cnt_reg != '0)
        begin
            // rotate so the dividend is back in place when done
            dvd_reg <= {dvd_reg[ACC_BITS-2:0], dvd_reg[ACC_BITS-1]};
            if (shifted >= {1'b0, dsr_reg})
                rem_reg <= diff[SB-1:0];
            else
                rem_reg <= shifted[SB-1:0];
        end
    end

    assign remainder    = rem_reg;
    assign dividend_out = dvd_reg;
    assign stat.busy    = (cnt_reg != '0) || full_reg;
    assign stat.valid   = full_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for string_bucket_hash: x37 key hashes and their bucket indexes.
`timescale 1ns / 1ps

module tb;

    localparam int                   UNIT_BITS      = sbh_pkg::UNIT_BITS;
    localparam int                   SIZE_BITS      = sbh_pkg::SIZE_BITS;

    localparam int                   ACC_W          = 64;
    localparam logic [ACC_W-1:0]     MULT_37        = 64'd37;
    localparam logic [UNIT_BITS-1:0] TERMINATOR     = 16'h0000;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX       = 31'h7FFF_FFFF;
    localparam logic [SIZE_BITS-1:0] SIZE_AT_RESET  = 31'd251;
    localparam int                   SETTLE_CYCLES  = ACC_W + 16;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   PHASE_UNITS    = 250;

    typedef struct packed {
        logic [SIZE_BITS-1:0] bucket;
        logic [ACC_W-1:0]     hash_value;
    } bucket_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [SIZE_BITS-1:0] cfg_wr_data = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [UNIT_BITS-1:0] code_unit   = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [SIZE_BITS-1:0] bucket;
    logic [ACC_W-1:0]     hash_value;

    logic [ACC_W-1:0]     hash_acc     = '0;
    logic [SIZE_BITS-1:0] table_size_q = SIZE_AT_RESET;
    bucket_result_t       pending_buckets[$];

    int errors          = 0;
    int units_taken     = 0;
    int keys_taken      = 0;
    int results_checked = 0;
    int size_writes     = 0;
    int quiet_cycles    = 0;
    int burst_left      = 0;
    bit gaps_on         = 1'b0;

    int stall_period = 4;
    int stall_duty   = 0;
    int stall_phase  = 0;
    int stall_hold   = 0;

    string_bucket_hash DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .bucket     (bucket),
        .hash_value (hash_value)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bucket_result_t hash_to_bucket(input logic [ACC_W-1:0] acc,
                                                      input logic [SIZE_BITS-1:0] size);
        logic [ACC_W-1:0] divisor;
        bucket_result_t   r;
        divisor      = (size == '0) ? ACC_W'(1) : ACC_W'(size);
        r.bucket     = SIZE_BITS'(acc % divisor);
        r.hash_value = acc;
        return r;
    endfunction

    // hash prediction on each accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            units_taken++;
            if (code_unit != TERMINATOR)
                hash_acc = hash_acc * MULT_37 + ACC_W'(code_unit);
            else
            begin
                pending_buckets.push_back(hash_to_bucket(hash_acc, table_size_q));
                hash_acc = '0;
                keys_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        bucket_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_buckets.size() == 0)
            begin
                $error("unexpected result beat: bucket=%0d hash_value=%h", bucket, hash_value);
                errors++;
            end
            else
            begin
                exp_r = pending_buckets.pop_front();
                results_checked++;
                if (bucket !== exp_r.bucket)
                begin
                    $error("bucket: expected %0d, got %0d", exp_r.bucket, bucket);
                    errors++;
                end
                if (hash_value !== exp_r.hash_value)
                begin
                    $error("hash_value: expected %h, got %h", exp_r.hash_value, hash_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver stall pattern: periodic duty cycle, re-picked at random when its hold runs out
    always @(negedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_hold   = $urandom_range(256, 64);
            stall_period = $urandom_range(16, 2);
            stall_duty   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(stall_period - 1, 1);
        end
        stall_hold--;
        stall_phase = (stall_phase + 1) % stall_period;
        out_stall <= (stall_phase < stall_duty);
    end

    task automatic pause_input(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_unit(input logic [UNIT_BITS-1:0] u);
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(20, 1);
            pause_input($urandom_range(8, 1));
        end
        if (burst_left > 0)
            burst_left--;
        in_valid  <= 1'b1;
        code_unit <= u;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle_block();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pending_buckets.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_table_size(input logic [SIZE_BITS-1:0] size);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        table_size_q  = size;
        size_writes++;
    endtask

    task automatic test_reset_table_size();
        gaps_on = 1'b0;
        send_unit(16'h0061);
        send_unit(16'h0062);
        send_unit(TERMINATOR);
        send_unit(TERMINATOR);      // empty key right behind a terminator
    endtask

    task automatic test_unit_extremes();
        gaps_on = 1'b1;
        send_unit(16'hFFFF);
        send_unit(16'h0001);
        send_unit(16'h8000);
        send_unit(16'h7FFF);
        send_unit(16'h5555);
        send_unit(16'hAAAA);
        send_unit(TERMINATOR);
    endtask

    task automatic test_table_size_extremes();
        set_table_size(31'd1);
        send_unit(16'h1234);
        send_unit(TERMINATOR);
        set_table_size('0);         // zero acts as one
        send_unit(16'h00FF);
        send_unit(TERMINATOR);
        set_table_size(SIZE_MAX);
        repeat (11) send_unit(16'hFFFF);    // wraps the accumulator
        send_unit(TERMINATOR);
    endtask

    task automatic test_random_keys(input logic [SIZE_BITS-1:0] size, input int budget);
        int sent;
        int key_len;
        int kind;
        sent = 0;
        set_table_size(size);
        gaps_on = ($urandom_range(3, 0) != 0);
        while (sent < budget)
        begin
            case ($urandom_range(19, 0))
                0:       key_len = $urandom_range(30, 17);
                1, 2, 3: key_len = $urandom_range(16, 9);
                default: key_len = $urandom_range(8, 0);
            endcase
            kind = $urandom_range(2, 0);
            for (int i = 0; i < key_len; i++)
            begin
                case (kind)
                    0:       send_unit(UNIT_BITS'($urandom_range(16'h007A, 16'h0061)));
                    1:       send_unit(UNIT_BITS'($urandom_range(16'hFFFF, 16'h0001)));
                    default: send_unit(UNIT_BITS'($urandom_range(16'hFFFF, 16'hFF00)));
                endcase
            end
            send_unit(TERMINATOR);
            sent += key_len + 1;
            if ($urandom_range(31, 0) == 0)
                gaps_on = ~gaps_on;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_table_size();
        test_unit_extremes();
        test_table_size_extremes();
        test_random_keys(SIZE_MAX, PHASE_UNITS);
        test_random_keys(31'd1, PHASE_UNITS);
        test_random_keys(SIZE_BITS'($urandom_range(SIZE_MAX, 1)), PHASE_UNITS);
        test_random_keys(SIZE_BITS'($urandom_range(1000, 2)), PHASE_UNITS);
        test_random_keys(SIZE_AT_RESET, PHASE_UNITS);

        in_valid <= 1'b0;
        while (pending_buckets.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d code units in %0d keys over %0d table size writes",
                 units_taken, keys_taken, size_writes);
        $display("Checked %0d bucket results, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
